FILE: design/tccf_pkg.sv
// Shared types, codes and helpers for the telephone call-control switch.
`default_nettype none

package tccf_pkg;

   // Number of telephone units; extension numbers are table indexes
   localparam int UNITS = 16;
   localparam int EXT_W = 4;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PICKUP = 2'd0,
      CMD_HANGUP = 2'd1,
      CMD_DIAL   = 2'd2,
      CMD_CHAT   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ON_HOOK   = 3'd0,
      ST_RINGING   = 3'd1,
      ST_DIAL_TONE = 3'd2,
      ST_RING_BACK = 3'd3,
      ST_BUSY      = 3'd4,
      ST_CONNECTED = 3'd5,
      ST_ERROR     = 3'd6
   } line_type;

   typedef enum logic [1:0] {
      KIND_STATE          = 2'd0,
      KIND_CHAT_DELIVERED = 2'd1,
      KIND_CHAT_REFUSED   = 2'd2
   } kind_type;

   typedef logic [EXT_W-1:0] ext_type;

   typedef struct packed {
      cmd_type cmd;
      ext_type unit;
      ext_type target;
      logic    target_found;
   } req_type;

   typedef struct packed {
      ext_type  dest_unit;
      kind_type kind;
      line_type line_state;
      logic     has_ext;
      ext_type  ext_shown;
      logic     last;
   } rsp_type;

   // Classified command as it sits in the queue
   typedef struct packed {
      cmd_type cmd;
      ext_type unit;
      ext_type target;
      logic    target_ok;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'd0,
      BK_RD_A  = 3'd1,
      BK_RD_B  = 3'd2,
      BK_EXEC  = 3'd3,
      BK_WR_B  = 3'd4,
      BK_EMIT0 = 3'd5,
      BK_EMIT1 = 3'd6
   } bk_state_type;

   // Build a notification: own extension on hook, peer extension when connected
   function automatic rsp_type notify_rsp(ext_type dest, kind_type kind, line_type st,
                                          logic linked, ext_type peer);
      rsp_type r;
      r.dest_unit  = dest;
      r.kind       = kind;
      r.line_state = st;
      r.last       = 1'b0;
      if (st == ST_ON_HOOK) begin
         r.has_ext   = 1'b1;
         r.ext_shown = dest;
      end else if (st == ST_CONNECTED && linked) begin
         r.has_ext   = 1'b1;
         r.ext_shown = peer;
      end else begin
         r.has_ext   = 1'b0;
         r.ext_shown = '0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/telephone_call_control_fsm_top.sv
// Top level of the telephone call-control switch.
`default_nettype none

// Call-control switch for 16 telephone units, each addressed by its extension.
// Requests (pickup, hangup, dial, chat) are accepted into a two-entry queue
// and then executed one at a time by a sequencer that reads the acting unit and
// the other party over a single table port, writes the two entries one after the
// other and then hands out zero, one or two notifications through an output
// register; the final notification of a request carries last. The sequencer
// steps through idle, read A, read B, execute and write B, then emits each
// notification once the output register is free, before it takes the next request.
// Requests keep being accepted while the sequencer works, until the queue is
// full. No clearing pass is needed after reset.
module telephone_call_control_fsm_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tccf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tccf_pkg::rsp_type      rsp_data
);
   import tccf_pkg::*;

   logic    q_valid;
   logic    q_pop;
   job_type q_job;

   tccf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_job     (q_job),
      .q_pop     (q_pop)
   );

   tccf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (q_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/tccf_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module tccf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tccf_pkg::req_type req_data,
   output logic                  q_valid,
   output tccf_pkg::job_type     q_job,
   input  wire logic             q_pop
);
   import tccf_pkg::*;

   job_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                unit_ok;
   logic                push;
   logic                pop;
   job_type             job_c;

   // Classify: drop units beyond the table, mark unknown targets
   assign unit_ok = ({1'b0, req_data.unit} < (EXT_W+1)'(UNITS));
   always_comb begin
      job_c.cmd       = req_data.cmd;
      job_c.unit      = req_data.unit;
      job_c.target    = req_data.target;
      job_c.target_ok = req_data.target_found &&
                        ({1'b0, req_data.target} < (EXT_W+1)'(UNITS));
   end

   assign req_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign push      = req_valid && req_ready && unit_ok;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_job     = q_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job_c;
      end
   end

endmodule

`default_nettype wire

FILE: design/tccf_back.sv
// Back end: reads both parties, applies the call transition and emits notifications.
`default_nettype none

module tccf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire tccf_pkg::job_type q_job,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tccf_pkg::rsp_type      rsp_data
);
   import tccf_pkg::*;

   // Per-unit tables
   line_type     line_st_ff  [UNITS];
   logic         peer_vld_ff [UNITS];
   ext_type      peer_idx_ff [UNITS];

   bk_state_type state_ff, state_in;
   job_type      job_ff, job_in;
   line_type     a_st_ff, a_st_in, b_st_ff, b_st_in;
   logic         a_vld_ff, a_vld_in, b_vld_ff, b_vld_in;
   ext_type      a_peer_ff, a_peer_in, b_peer_ff, b_peer_in;
   ext_type      b_addr_ff, b_addr_in;
   rsp_type      res0_ff, res0_in, res1_ff, res1_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         bw_en_ff, bw_en_in, bw_vld_ff, bw_vld_in;
   line_type     bw_st_ff, bw_st_in;
   ext_type      bw_peer_ff, bw_peer_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   ext_type      rd_addr;
   line_type     rd_st;
   logic         rd_vld;
   ext_type      rd_peer;
   ext_type      b_addr_c;
   logic         tw_en, tw_vld;
   ext_type      tw_addr, tw_peer;
   line_type     tw_st;
   logic         out_free;

   // Transition results for the current command
   logic         aw_en, aw_vld, bw_en_c, bw_vld_c;
   line_type     aw_st, bw_st_c;
   ext_type      aw_peer, bw_peer_c;
   rsp_type      r0_c, r1_c;
   logic [1:0]   cnt_c;

   // Single table read port
   assign rd_st   = line_st_ff[rd_addr];
   assign rd_vld  = peer_vld_ff[rd_addr];
   assign rd_peer = peer_idx_ff[rd_addr];
   assign b_addr_c = (job_ff.cmd == CMD_DIAL) ? job_ff.target : a_peer_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decide the call transition from both parties' entries
   always_comb begin
      aw_en     = 1'b0;
      aw_st     = a_st_ff;
      aw_vld    = a_vld_ff;
      aw_peer   = a_peer_ff;
      bw_en_c   = 1'b0;
      bw_st_c   = b_st_ff;
      bw_vld_c  = b_vld_ff;
      bw_peer_c = b_peer_ff;
      r0_c      = '0;
      r1_c      = '0;
      cnt_c     = 2'd0;
      case (job_ff.cmd)
         CMD_PICKUP: begin
            if (a_st_ff == ST_ON_HOOK) begin
               aw_en = 1'b1;
               aw_st = ST_DIAL_TONE;
               r0_c  = notify_rsp(job_ff.unit, KIND_STATE, ST_DIAL_TONE,
                                  a_vld_ff, a_peer_ff);
               cnt_c = 2'd1;
            end else if (a_st_ff == ST_RINGING) begin
               aw_en = 1'b1;
               aw_st = ST_CONNECTED;
               r0_c  = notify_rsp(job_ff.unit, KIND_STATE, ST_CONNECTED,
                                  a_vld_ff, a_peer_ff);
               cnt_c = 2'd1;
               if (a_vld_ff) begin
                  bw_en_c = 1'b1;
                  bw_st_c = ST_CONNECTED;
                  r1_c    = notify_rsp(a_peer_ff, KIND_STATE, ST_CONNECTED,
                                       b_vld_ff, b_peer_ff);
                  cnt_c   = 2'd2;
               end
            end
         end
         CMD_HANGUP: begin
            if (a_st_ff != ST_ON_HOOK) begin
               aw_en  = 1'b1;
               aw_st  = ST_ON_HOOK;
               aw_vld = 1'b0;
               r0_c   = notify_rsp(job_ff.unit, KIND_STATE, ST_ON_HOOK, 1'b0, a_peer_ff);
               cnt_c  = 2'd1;
               if (a_vld_ff) begin
                  // Drop the link on both sides
                  bw_en_c  = 1'b1;
                  bw_vld_c = 1'b0;
                  if (a_st_ff == ST_CONNECTED || a_st_ff == ST_RINGING) begin
                     bw_st_c = ST_DIAL_TONE;
                     r1_c    = notify_rsp(a_peer_ff, KIND_STATE, ST_DIAL_TONE,
                                          1'b0, b_peer_ff);
                     cnt_c   = 2'd2;
                  end else if (a_st_ff == ST_RING_BACK) begin
                     bw_st_c = ST_ON_HOOK;
                     r1_c    = notify_rsp(a_peer_ff, KIND_STATE, ST_ON_HOOK,
                                          1'b0, b_peer_ff);
                     cnt_c   = 2'd2;
                  end
               end
            end
         end
         CMD_DIAL: begin
            if (a_st_ff == ST_DIAL_TONE) begin
               aw_en = 1'b1;
               cnt_c = 2'd1;
               if (!job_ff.target_ok) begin
                  aw_st = ST_ERROR;
                  r0_c  = notify_rsp(job_ff.unit, KIND_STATE, ST_ERROR,
                                     a_vld_ff, a_peer_ff);
               end else if (job_ff.target == job_ff.unit || b_vld_ff ||
                            b_st_ff != ST_ON_HOOK) begin
                  aw_st = ST_BUSY;
                  r0_c  = notify_rsp(job_ff.unit, KIND_STATE, ST_BUSY,
                                     a_vld_ff, a_peer_ff);
               end else begin
                  // Link caller and target
                  aw_st     = ST_RING_BACK;
                  aw_vld    = 1'b1;
                  aw_peer   = job_ff.target;
                  bw_en_c   = 1'b1;
                  bw_st_c   = ST_RINGING;
                  bw_vld_c  = 1'b1;
                  bw_peer_c = job_ff.unit;
                  r0_c      = notify_rsp(job_ff.target, KIND_STATE, ST_RINGING,
                                         1'b1, job_ff.unit);
                  r1_c      = notify_rsp(job_ff.unit, KIND_STATE, ST_RING_BACK,
                                         1'b1, job_ff.target);
                  cnt_c     = 2'd2;
               end
            end
         end
         CMD_CHAT: begin
            if (a_st_ff == ST_CONNECTED && a_vld_ff) begin
               r0_c.dest_unit  = a_peer_ff;
               r0_c.kind       = KIND_CHAT_DELIVERED;
               r0_c.line_state = ST_CONNECTED;
               r0_c.has_ext    = 1'b1;
               r0_c.ext_shown  = job_ff.unit;
               r0_c.last       = 1'b0;
               r1_c  = notify_rsp(job_ff.unit, KIND_STATE, ST_CONNECTED, 1'b1, a_peer_ff);
               cnt_c = 2'd2;
            end else begin
               r0_c  = notify_rsp(job_ff.unit, KIND_CHAT_REFUSED, a_st_ff,
                                  a_vld_ff, a_peer_ff);
               cnt_c = 2'd1;
            end
         end
         default: begin
            cnt_c = 2'd0;
         end
      endcase
      // Mark the final result of the command
      if (cnt_c == 2'd1) begin
         r0_c.last = 1'b1;
      end
      if (cnt_c == 2'd2) begin
         r1_c.last = 1'b1;
      end
   end

   // Sequencer: next state, table access and result hand-off
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      a_st_in      = a_st_ff;
      a_vld_in     = a_vld_ff;
      a_peer_in    = a_peer_ff;
      b_st_in      = b_st_ff;
      b_vld_in     = b_vld_ff;
      b_peer_in    = b_peer_ff;
      b_addr_in    = b_addr_ff;
      res0_in      = res0_ff;
      res1_in      = res1_ff;
      cnt_in       = cnt_ff;
      bw_en_in     = bw_en_ff;
      bw_st_in     = bw_st_ff;
      bw_vld_in    = bw_vld_ff;
      bw_peer_in   = bw_peer_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      rd_addr      = job_ff.unit;
      tw_en        = 1'b0;
      tw_addr      = job_ff.unit;
      tw_st        = aw_st;
      tw_vld       = aw_vld;
      tw_peer      = aw_peer;
      case (state_ff)
         BK_IDLE: begin
            q_pop = 1'b1;
            if (q_valid) begin
               job_in   = q_job;
               state_in = BK_RD_A;
            end
         end
         BK_RD_A: begin
            rd_addr   = job_ff.unit;
            a_st_in   = rd_st;
            a_vld_in  = rd_vld;
            a_peer_in = rd_peer;
            state_in  = BK_RD_B;
         end
         BK_RD_B: begin
            rd_addr   = b_addr_c;
            b_addr_in = b_addr_c;
            b_st_in   = rd_st;
            b_vld_in  = rd_vld;
            b_peer_in = rd_peer;
            state_in  = BK_EXEC;
         end
         BK_EXEC: begin
            tw_en      = aw_en;
            res0_in    = r0_c;
            res1_in    = r1_c;
            cnt_in     = cnt_c;
            bw_en_in   = bw_en_c;
            bw_st_in   = bw_st_c;
            bw_vld_in  = bw_vld_c;
            bw_peer_in = bw_peer_c;
            state_in   = BK_WR_B;
         end
         BK_WR_B: begin
            tw_en    = bw_en_ff;
            tw_addr  = b_addr_ff;
            tw_st    = bw_st_ff;
            tw_vld   = bw_vld_ff;
            tw_peer  = bw_peer_ff;
            state_in = (cnt_ff == 2'd0) ? BK_IDLE : BK_EMIT0;
         end
         BK_EMIT0: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res0_ff;
               state_in     = (cnt_ff == 2'd2) ? BK_EMIT1 : BK_IDLE;
            end
         end
         BK_EMIT1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res1_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      a_st_ff     <= a_st_in;
      a_vld_ff    <= a_vld_in;
      a_peer_ff   <= a_peer_in;
      b_st_ff     <= b_st_in;
      b_vld_ff    <= b_vld_in;
      b_peer_ff   <= b_peer_in;
      b_addr_ff   <= b_addr_in;
      res0_ff     <= res0_in;
      res1_ff     <= res1_in;
      cnt_ff      <= cnt_in;
      bw_en_ff    <= bw_en_in;
      bw_st_ff    <= bw_st_in;
      bw_vld_ff   <= bw_vld_in;
      bw_peer_ff  <= bw_peer_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Line state and link bits: all on hook and unlinked after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < UNITS; i++) begin
            line_st_ff[i]  <= ST_ON_HOOK;
            peer_vld_ff[i] <= 1'b0;
         end
      end else if (tw_en) begin
         line_st_ff[tw_addr]  <= tw_st;
         peer_vld_ff[tw_addr] <= tw_vld;
      end
   end

   // Peer index: meaningful only while the link bit is set
   always_ff @(posedge clock) begin
      if (tw_en) begin
         peer_idx_ff[tw_addr] <= tw_peer;
      end
   end

endmodule

`default_nettype wire
